>>> sv/assert_macros.svh
// Assertion helpers: clocked on clk_i, held off while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication, checked at every rising edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition that must never hold outside reset.
`define ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

>>> sv/bmc_pkg.sv
package bmc_pkg;

  localparam int MaxRows = 1024;
  localparam int MaxCols = 1024;

  localparam int CoordW = 10;
  localparam int CountW = 21;
  localparam int SumW   = 30;

  // one quotient bit per step
  localparam int DivSteps = SumW;
  localparam int StepW    = $clog2(DivSteps);

  typedef struct packed {
    logic pix_en;     // pixel beat accepted
    logic start_div;  // frame end: snapshot sums, clear accumulators
    logic div_step;   // one divider iteration
    logic load_out;   // move quotients to the output register
  } cmd_t;

  typedef struct packed {
    logic last_step;
  } sts_t;

endpackage

>>> sv/bmc_datapath.sv
module bmc_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  bmc_pkg::cmd_t                 cmd_i,
  output bmc_pkg::sts_t                 sts_o,
  input  logic                          mask_pixel_i,
  input  logic [bmc_pkg::CoordW-1:0]    pixel_row_i,
  input  logic [bmc_pkg::CoordW-1:0]    pixel_col_i,
  output logic [bmc_pkg::CoordW-1:0]    centroid_row_o,
  output logic [bmc_pkg::CoordW-1:0]    centroid_col_o,
  output logic [bmc_pkg::CountW-1:0]    foreground_count_o,
  output logic                          found_o
);

  typedef struct packed {
    logic [bmc_pkg::CountW-1:0] rem;
    logic [bmc_pkg::SumW-1:0]   quo;
  } div_t;

  function automatic div_t div_iter(input div_t cur, input logic [bmc_pkg::CountW-1:0] den);
    logic [bmc_pkg::CountW:0] sh;
    logic [bmc_pkg::CountW:0] diff;
    div_t                     nx;
    sh   = {cur.rem, cur.quo[bmc_pkg::SumW-1]};
    diff = sh - {1'b0, den};
    if (!diff[bmc_pkg::CountW]) begin
      nx.rem = diff[bmc_pkg::CountW-1:0];
      nx.quo = {cur.quo[bmc_pkg::SumW-2:0], 1'b1};
    end else begin
      nx.rem = sh[bmc_pkg::CountW-1:0];
      nx.quo = {cur.quo[bmc_pkg::SumW-2:0], 1'b0};
    end
    return nx;
  endfunction

  function automatic logic [bmc_pkg::CoordW-1:0] clamp(input logic [bmc_pkg::SumW-1:0] q);
    logic [bmc_pkg::CoordW-1:0] r;
    if (|q[bmc_pkg::SumW-1:bmc_pkg::CoordW]) begin
      r = '1;
    end else begin
      r = q[bmc_pkg::CoordW-1:0];
    end
    return r;
  endfunction

  logic [bmc_pkg::CountW-1:0] count_acc_q, count_acc_d;
  logic [bmc_pkg::SumW-1:0]   row_sum_q, row_sum_d;
  logic [bmc_pkg::SumW-1:0]   col_sum_q, col_sum_d;
  logic [bmc_pkg::StepW-1:0]  step_q;

  logic [bmc_pkg::CountW:0]   cnt_inc;
  logic [bmc_pkg::SumW:0]     row_add, col_add;
  logic                       hit;

  div_t                       row_div_q, col_div_q;
  logic [bmc_pkg::CountW-1:0] den_q;

  logic [bmc_pkg::CoordW-1:0] cen_row_q, cen_col_q;
  logic [bmc_pkg::CountW-1:0] cnt_out_q;
  logic                       found_q;

  always_comb begin
    hit     = mask_pixel_i && (int'(pixel_row_i) < bmc_pkg::MaxRows)
                           && (int'(pixel_col_i) < bmc_pkg::MaxCols);
    cnt_inc = {1'b0, count_acc_q} + (bmc_pkg::CountW+1)'(1);
    row_add = {1'b0, row_sum_q} + (bmc_pkg::SumW+1)'(pixel_row_i);
    col_add = {1'b0, col_sum_q} + (bmc_pkg::SumW+1)'(pixel_col_i);
    count_acc_d = count_acc_q;
    row_sum_d   = row_sum_q;
    col_sum_d   = col_sum_q;
    if (cmd_i.pix_en && hit) begin
      count_acc_d = cnt_inc[bmc_pkg::CountW] ? '1 : cnt_inc[bmc_pkg::CountW-1:0];
      row_sum_d   = row_add[bmc_pkg::SumW] ? '1 : row_add[bmc_pkg::SumW-1:0];
      col_sum_d   = col_add[bmc_pkg::SumW] ? '1 : col_add[bmc_pkg::SumW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_acc_q <= '0;
      row_sum_q   <= '0;
      col_sum_q   <= '0;
      step_q      <= '0;
    end else begin
      if (cmd_i.start_div) begin
        count_acc_q <= '0;
        row_sum_q   <= '0;
        col_sum_q   <= '0;
        step_q      <= '0;
      end else begin
        count_acc_q <= count_acc_d;
        row_sum_q   <= row_sum_d;
        col_sum_q   <= col_sum_d;
        if (cmd_i.div_step) begin
          step_q <= step_q + (bmc_pkg::StepW)'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start_div) begin
      den_q         <= count_acc_d;
      row_div_q.rem <= '0;
      row_div_q.quo <= row_sum_d;
      col_div_q.rem <= '0;
      col_div_q.quo <= col_sum_d;
    end else if (cmd_i.div_step) begin
      row_div_q <= div_iter(row_div_q, den_q);
      col_div_q <= div_iter(col_div_q, den_q);
    end
    if (cmd_i.load_out) begin
      found_q   <= |den_q;
      cnt_out_q <= den_q;
      cen_row_q <= (|den_q) ? clamp(row_div_q.quo) : '0;
      cen_col_q <= (|den_q) ? clamp(col_div_q.quo) : '0;
    end
  end

  assign sts_o.last_step   = (step_q == (bmc_pkg::StepW)'(bmc_pkg::DivSteps - 1));
  assign centroid_row_o     = cen_row_q;
  assign centroid_col_o     = cen_col_q;
  assign foreground_count_o = cnt_out_q;
  assign found_o            = found_q;

endmodule

>>> sv/bmc_ctrl.sv
`include "assert_macros.svh"

module bmc_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          frame_end_i,
  output logic          in_stall_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  input  bmc_pkg::sts_t sts_i,
  output bmc_pkg::cmd_t cmd_o
);

  typedef enum logic [1:0] {
    ST_RUN,
    ST_DIV,
    ST_FINISH
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   in_take;
  logic   out_take;
  logic   out_free;

  always_comb begin
    in_take  = in_valid_i && (state_q == ST_RUN);
    out_take = out_valid_q && !out_stall_i;
    out_free = !out_valid_q || !out_stall_i;
    cmd_o.pix_en    = in_take;
    cmd_o.start_div = in_take && frame_end_i;
    cmd_o.div_step  = (state_q == ST_DIV);
    cmd_o.load_out  = (state_q == ST_FINISH) && out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_RUN;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_o.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_take) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_RUN: begin
          if (cmd_o.start_div) begin
            state_q <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (sts_i.last_step) begin
            state_q <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (out_free) begin
            state_q <= ST_RUN;
          end
        end
        default: state_q <= ST_RUN;
      endcase
    end
  end

  assign in_stall_o  = (state_q != ST_RUN);
  assign out_valid_o = out_valid_q;

  `ASSERT_CLK(a_start_enters_div, cmd_o.start_div |=> (state_q == ST_DIV), "frame end did not start division")
  `ASSERT_CLK(a_load_sets_valid, cmd_o.load_out |=> out_valid_q, "result load lost")
  `ASSERT_NEVER(a_no_overwrite, cmd_o.load_out && out_valid_q && out_stall_i, "pending result overwritten")

endmodule

>>> sv/binary_mask_centroid.sv
// Channel  Dir  Handshake            Beat payload
// in       in   in_valid_i/in_stall_o   mask_pixel_i, pixel_row_i, pixel_col_i, frame_end_i
// out      out  out_valid_o/out_stall_i centroid_row_o, centroid_col_o,
//                                       foreground_count_o, found_o
//
// One pixel beat per cycle while accumulating.
// A frame end beat starts a restoring divider, one quotient bit per cycle for both
// sums in parallel: input stalled while dividing and loading the result, plus any wait for the output slot.
// The result sits in an output register; pixels of the next frame flow meanwhile.
// Reset (async, active low) clears the accumulators and leaves the output empty.
module binary_mask_centroid (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic                       mask_pixel_i,
  input  logic [bmc_pkg::CoordW-1:0] pixel_row_i,
  input  logic [bmc_pkg::CoordW-1:0] pixel_col_i,
  input  logic                       frame_end_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [bmc_pkg::CoordW-1:0] centroid_row_o,
  output logic [bmc_pkg::CoordW-1:0] centroid_col_o,
  output logic [bmc_pkg::CountW-1:0] foreground_count_o,
  output logic                       found_o
);

  bmc_pkg::cmd_t cmd;
  bmc_pkg::sts_t sts;

  bmc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .frame_end_i (frame_end_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  bmc_datapath u_datapath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .sts_o              (sts),
    .mask_pixel_i       (mask_pixel_i),
    .pixel_row_i        (pixel_row_i),
    .pixel_col_i        (pixel_col_i),
    .centroid_row_o     (centroid_row_o),
    .centroid_col_o     (centroid_col_o),
    .foreground_count_o (foreground_count_o),
    .found_o            (found_o)
  );

endmodule

>>> tb/tb.sv
`timescale 1ns / 100ps

module tb;

  localparam int CoordMax      = 2 ** bmc_pkg::CoordW - 1;
  localparam int PhaseBeats    = 325;
  localparam int CycleLimit    = 300000;

  typedef struct packed {
    logic [bmc_pkg::CoordW-1:0] row;
    logic [bmc_pkg::CoordW-1:0] col;
    logic [bmc_pkg::CountW-1:0] count;
    logic                       found;
  } centroid_t;

  class centroid_predictor;
    logic [bmc_pkg::CountW-1:0] fg_count;
    logic [bmc_pkg::SumW-1:0]   row_total;
    logic [bmc_pkg::SumW-1:0]   col_total;
    centroid_t                  results_q[$];
    int                         errors;

    function new();
      fg_count  = '0;
      row_total = '0;
      col_total = '0;
      errors    = 0;
    endfunction

    function logic [bmc_pkg::CoordW-1:0] mean_coord(logic [bmc_pkg::SumW-1:0] total,
                                                    logic [bmc_pkg::CountW-1:0] n);
      logic [bmc_pkg::SumW-1:0] q;
      if (n == 0) return '0;
      q = total / n;
      return (q > CoordMax) ? '1 : q[bmc_pkg::CoordW-1:0];
    endfunction

    function void note_pixel(logic pix, logic [bmc_pkg::CoordW-1:0] row,
                             logic [bmc_pkg::CoordW-1:0] col, logic last);
      logic [bmc_pkg::SumW:0] row_next;
      logic [bmc_pkg::SumW:0] col_next;
      centroid_t              res;
      if (pix && row < bmc_pkg::MaxRows && col < bmc_pkg::MaxCols) begin
        if (fg_count != '1) fg_count = fg_count + 1'b1;
        row_next  = {1'b0, row_total} + (bmc_pkg::SumW+1)'(row);
        col_next  = {1'b0, col_total} + (bmc_pkg::SumW+1)'(col);
        row_total = row_next[bmc_pkg::SumW] ? '1 : row_next[bmc_pkg::SumW-1:0];
        col_total = col_next[bmc_pkg::SumW] ? '1 : col_next[bmc_pkg::SumW-1:0];
      end
      if (!last) return;
      res.row   = mean_coord(row_total, fg_count);
      res.col   = mean_coord(col_total, fg_count);
      res.count = fg_count;
      res.found = (fg_count != 0);
      results_q.push_back(res);
      fg_count  = '0;
      row_total = '0;
      col_total = '0;
    endfunction

    function void compare(string field, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $display("%0t: %s expected %0d actual %0d", $time, field, want, got);
        errors++;
      end
    endfunction

    function void check_result(centroid_t got);
      centroid_t want;
      if (results_q.size() == 0) begin
        $display("%0t: unexpected beat row %0d col %0d count %0d found %0d", $time,
                 got.row, got.col, got.count, got.found);
        errors++;
        return;
      end
      want = results_q.pop_front();
      compare("centroid_row", 32'(want.row), 32'(got.row));
      compare("centroid_col", 32'(want.col), 32'(got.col));
      compare("foreground_count", 32'(want.count), 32'(got.count));
      compare("found", 32'(want.found), 32'(got.found));
    endfunction

    function int pending();
      return results_q.size();
    endfunction
  endclass

  logic                       clk       = 1'b0;
  logic                       rst_n     = 1'b0;
  logic                       in_valid  = 1'b0;
  logic                       in_stall;
  logic                       mask_pixel = 1'b0;
  logic [bmc_pkg::CoordW-1:0] pixel_row = '0;
  logic [bmc_pkg::CoordW-1:0] pixel_col = '0;
  logic                       frame_end = 1'b0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic [bmc_pkg::CoordW-1:0] centroid_row;
  logic [bmc_pkg::CoordW-1:0] centroid_col;
  logic [bmc_pkg::CountW-1:0] foreground_count;
  logic                       found;

  centroid_predictor centroids = new();
  int                in_idle_pct   = 0;
  int                out_stall_pct = 0;
  int                hold_cycles   = 0;
  int                pixels_sent   = 0;
  int                cycles        = 0;

  binary_mask_centroid i_dut (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .in_valid_i        (in_valid),
    .in_stall_o        (in_stall),
    .mask_pixel_i      (mask_pixel),
    .pixel_row_i       (pixel_row),
    .pixel_col_i       (pixel_col),
    .frame_end_i       (frame_end),
    .out_valid_o       (out_valid),
    .out_stall_i       (out_stall),
    .centroid_row_o    (centroid_row),
    .centroid_col_o    (centroid_col),
    .foreground_count_o(foreground_count),
    .found_o           (found)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      centroids.check_result('{centroid_row, centroid_col, foreground_count, found});
    end
    if (rst_n && in_valid && !in_stall) begin
      centroids.note_pixel(mask_pixel, pixel_row, pixel_col, frame_end);
    end
  end

  // receiver: random stall, or a long hold-off when requested
  initial begin
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        out_stall <= 1'b1;
        hold_cycles--;
      end else begin
        out_stall <= ($urandom_range(0, 99) < out_stall_pct);
      end
    end
  end

  // entered and left just after a falling edge
  task automatic send_pixel(input logic pix, input logic [bmc_pkg::CoordW-1:0] row,
                            input logic [bmc_pkg::CoordW-1:0] col, input logic last);
    while (in_idle_pct != 0 && $urandom_range(0, 99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    mask_pixel <= pix;
    pixel_row  <= row;
    pixel_col  <= col;
    frame_end  <= last;
    do @(posedge clk); while (in_stall);
    pixels_sent++;
    @(negedge clk);
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    while (centroids.pending() != 0) @(negedge clk);
  endtask

  // small raster window at a random place, or scattered coordinates
  task automatic send_random_frame();
    int                         h;
    int                         w;
    int                         density;
    int                         r0;
    int                         c0;
    bit                         scatter;
    logic [bmc_pkg::CoordW-1:0] row;
    logic [bmc_pkg::CoordW-1:0] col;
    h       = $urandom_range(1, 6);
    w       = $urandom_range(1, 8);
    r0      = $urandom_range(0, bmc_pkg::MaxRows - h);
    c0      = $urandom_range(0, bmc_pkg::MaxCols - w);
    density = 25 * $urandom_range(0, 4);
    scatter = ($urandom_range(0, 3) == 0);
    for (int r = 0; r < h; r++) begin
      for (int c = 0; c < w; c++) begin
        row = (bmc_pkg::CoordW)'(scatter ? $urandom_range(0, CoordMax) : r0 + r);
        col = (bmc_pkg::CoordW)'(scatter ? $urandom_range(0, CoordMax) : c0 + c);
        send_pixel($urandom_range(1, 100) <= density, row, col, r == h - 1 && c == w - 1);
      end
    end
  endtask

  initial begin
    int target;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_pixel(1'b0, 10'd0, 10'd0, 1'b1);           // empty frame
    send_pixel(1'b1, 10'd1023, 10'd1023, 1'b1);
    send_pixel(1'b1, 10'd0, 10'd0, 1'b1);
    send_pixel(1'b1, 10'd0, 10'd0, 1'b0);
    send_pixel(1'b1, 10'd1023, 10'd1023, 1'b0);
    send_pixel(1'b0, 10'd5, 10'd5, 1'b1);
    send_pixel(1'b1, 10'd1023, 10'd0, 1'b0);
    send_pixel(1'b1, 10'd0, 10'd1023, 1'b1);
    send_pixel(1'b1, 10'd1, 10'd2, 1'b0);
    send_pixel(1'b1, 10'd3, 10'd4, 1'b0);
    send_pixel(1'b1, 10'd2, 10'd7, 1'b0);
    send_pixel(1'b0, 10'd1023, 10'd1023, 1'b1);
    send_pixel(1'b0, 10'd1023, 10'd1023, 1'b0);
    send_pixel(1'b1, 10'd512, 10'd256, 1'b0);
    send_pixel(1'b0, 10'd0, 10'd0, 1'b1);
    send_pixel(1'b1, 10'd682, 10'd341, 1'b0);
    send_pixel(1'b1, 10'd341, 10'd682, 1'b1);
    send_pixel(1'b0, 10'd341, 10'd682, 1'b1);
    wait_drain();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          in_idle_pct   = 0;
          out_stall_pct = 0;
          hold_cycles   = 400;
        end
        1: begin
          in_idle_pct   = 88;
          out_stall_pct = 0;
        end
        2: begin
          in_idle_pct   = 0;
          out_stall_pct = 88;
        end
        default: begin
          in_idle_pct   = 9;
          out_stall_pct = 9;
        end
      endcase
      target = pixels_sent + PhaseBeats;
      while (pixels_sent < target) begin
        send_random_frame();
        if (ph == 2 && pixels_sent >= target - PhaseBeats / 2 && centroids.pending() > 0
            && $urandom_range(0, 7) == 0) begin
          wait_drain();
          @(negedge clk);
        end
      end
    end

    wait_drain();
    repeat (60) @(posedge clk);
    if (centroids.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+sv
sv/bmc_pkg.sv
sv/bmc_datapath.sv
sv/bmc_ctrl.sv
sv/binary_mask_centroid.sv
tb/tb.sv
